>>> rtl/assert_macros.svh
// Assertion helpers for the supervisor checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define AST_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/fsts_pkg.sv
`default_nettype none
package fsts_pkg;

    localparam int unsigned CfgIdxW   = 3;
    localparam int unsigned CfgDataW  = 32;
    localparam int unsigned TicksW    = 32;
    localparam int unsigned LimitW    = 8;
    localparam int unsigned RespW     = 24;
    localparam int unsigned FuncW     = 2;
    localparam int unsigned EventW    = 3;
    localparam int unsigned ActionW   = 2;
    localparam int unsigned ModeW     = 3;
    localparam int unsigned QueueDepth = 4;

    localparam logic [FuncW-1:0] FUNC_TICK     = 2'd0;
    localparam logic [FuncW-1:0] FUNC_CPU_SEEN = 2'd1;
    localparam logic [FuncW-1:0] FUNC_POSITION = 2'd2;
    localparam logic [FuncW-1:0] FUNC_EXTERNAL = 2'd3;

    localparam logic [EventW-1:0] EV_CPU_TIMEOUT = 3'd1;
    localparam logic [EventW-1:0] EV_CPU_FAILURE = 3'd2;
    localparam logic [EventW-1:0] EV_GPS_TIMEOUT = 3'd3;
    localparam logic [EventW-1:0] EV_GPS_FAILURE = 3'd4;
    localparam logic [EventW-1:0] EV_BOUNDARY    = 3'd6;

    localparam logic [ActionW-1:0] ACT_IGNORE    = 2'd0;
    localparam logic [ActionW-1:0] ACT_RESTART   = 2'd1;
    localparam logic [ActionW-1:0] ACT_PWM_OFF   = 2'd2;
    localparam logic [ActionW-1:0] ACT_TERMINATE = 2'd3;

    localparam logic [ModeW-1:0] MODE_RESTART = 3'd1;
    localparam logic [ModeW-1:0] MODE_IGNORE  = 3'd2;
    localparam logic [ModeW-1:0] MODE_PWM_OFF = 3'd3;

    localparam logic [CfgIdxW-1:0] CFG_CPU_TIMEOUT  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_CPU_FAILURE  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_GPS_TIMEOUT  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_GPS_FAILURE  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_BOUND_LIMIT  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_RESP_TABLE   = 3'd5;

    localparam logic [TicksW-1:0] CPU_TIMEOUT_RST = 32'd5;
    localparam logic [TicksW-1:0] CPU_FAILURE_RST = 32'd50;
    localparam logic [TicksW-1:0] GPS_TIMEOUT_RST = 32'd10;
    localparam logic [TicksW-1:0] GPS_FAILURE_RST = 32'd100;
    localparam logic [LimitW-1:0] BOUND_LIMIT_RST = 8'd10;
    localparam logic [RespW-1:0]  RESP_TABLE_RST  = 24'd9512156;

    typedef struct packed {
        logic [EventW-1:0]  event_code;
        logic [ActionW-1:0] action;
        logic               last;
    } t_result;

    function automatic logic [ActionW-1:0] map_mode(input logic [ModeW-1:0] mode);
        logic [ActionW-1:0] act;
        case (mode)
            MODE_RESTART: act = ACT_RESTART;
            MODE_IGNORE:  act = ACT_IGNORE;
            MODE_PWM_OFF: act = ACT_PWM_OFF;
            default:      act = ACT_TERMINATE;
        endcase
        return act;
    endfunction

endpackage
`default_nettype wire

>>> rtl/failsafe_timeout_supervisor.sv
// Results of an item are written into the queue as it is accepted, behind older ones.
// Throughput: one item per cycle while input ready is high; it drops while fewer than
// two of the four queue entries are free. Results leave one per cycle on i_out_ready.
// Reset (synchronous, active low): thresholds and response table to defaults,
// staleness counters and boundary run to zero, terminate latch cleared, queue empty.
`default_nettype none
module failsafe_timeout_supervisor (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire  [fsts_pkg::CfgIdxW-1:0]           i_cfg_index,
    input  wire  [fsts_pkg::CfgDataW-1:0]          i_cfg_data,
    input  wire                                    i_in_valid,
    output logic                                   o_in_ready,
    input  wire  [fsts_pkg::FuncW-1:0]             i_func,
    input  wire                                    i_out_of_bounds,
    input  wire  [fsts_pkg::EventW-1:0]            i_event_id,
    output logic                                   o_out_valid,
    input  wire                                    i_out_ready,
    output logic [fsts_pkg::EventW-1:0]            o_event_code,
    output logic [fsts_pkg::ActionW-1:0]           o_action,
    output logic                                   o_last
);
    import fsts_pkg::*;

    localparam int unsigned PtrW = $clog2(QueueDepth);
    localparam int unsigned CntW = $clog2(QueueDepth + 1);

    logic [TicksW-1:0] r_cpu_timeout, r_cpu_failure, r_gps_timeout, r_gps_failure;
    logic [LimitW-1:0] r_bound_limit;
    logic [RespW-1:0]  r_resp_table;

    // Ticks since last CPU packet / position report, minus one on the next tick.
    logic [TicksW-1:0] r_cpu_delta, n_cpu_delta;
    logic [TicksW-1:0] r_gps_delta, n_gps_delta;
    logic [LimitW-1:0] r_exceed, n_exceed;
    logic              r_terminated, n_terminated;

    t_result           r_queue [QueueDepth];
    logic [PtrW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0]   r_count;

    logic              in_fire, out_fire;
    logic              a_valid, b_valid;
    logic [EventW-1:0] a_ev, b_ev, s0_ev;
    logic [ActionW-1:0] a_act, b_act, s0_act;
    logic              s0_valid, s1_valid;
    logic              cpu_fail, cpu_to, gps_fail, gps_to;
    logic [LimitW-1:0] exceed_inc;
    t_result           s0_res, s1_res;
    logic [PtrW-1:0]   wr_ptr_1;
    logic [1:0]        push_n;

    function automatic logic [ActionW-1:0] lookup(input logic [RespW-1:0] tbl,
                                                  input logic [EventW-1:0] ev);
        logic [4:0] base;
        base = {2'b00, ev} * 5'd3;
        return map_mode(tbl[base +: ModeW]);
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_count <= CntW'(QueueDepth - 2));
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = o_out_valid && i_out_ready;

    assign cpu_fail = (r_cpu_delta != '1) && (r_cpu_delta >= r_cpu_failure);
    assign cpu_to   = (r_cpu_delta != '1) && (r_cpu_delta >= r_cpu_timeout);
    assign gps_fail = (r_gps_delta != '1) && (r_gps_delta >= r_gps_failure);
    assign gps_to   = (r_gps_delta != '1) && (r_gps_delta >= r_gps_timeout);
    assign exceed_inc = (r_exceed < r_bound_limit) ? r_exceed + LimitW'(1) : r_exceed;

    always_comb begin
        a_valid      = 1'b0;
        a_ev         = EV_CPU_FAILURE;
        b_valid      = 1'b0;
        b_ev         = EV_GPS_FAILURE;
        n_cpu_delta  = r_cpu_delta;
        n_gps_delta  = r_gps_delta;
        n_exceed     = r_exceed;
        unique case (i_func)
            FUNC_TICK: begin
                n_cpu_delta = r_cpu_delta + TicksW'(1);
                n_gps_delta = r_gps_delta + TicksW'(1);
                a_valid     = cpu_fail || cpu_to;
                a_ev        = cpu_fail ? EV_CPU_FAILURE : EV_CPU_TIMEOUT;
                b_valid     = gps_fail || gps_to;
                b_ev        = gps_fail ? EV_GPS_FAILURE : EV_GPS_TIMEOUT;
            end
            FUNC_CPU_SEEN: begin
                n_cpu_delta = '0;
            end
            FUNC_POSITION: begin
                n_gps_delta = '0;
                if (i_out_of_bounds) begin
                    n_exceed = exceed_inc;
                    a_valid  = (exceed_inc >= r_bound_limit);
                    a_ev     = EV_BOUNDARY;
                end else begin
                    n_exceed = '0;
                end
            end
            FUNC_EXTERNAL: begin
                a_valid = 1'b1;
                a_ev    = i_event_id;
            end
            default: begin
                a_valid = 1'b0;
            end
        endcase
        a_act    = lookup(r_resp_table, a_ev);
        b_act    = lookup(r_resp_table, b_ev);
        s0_valid = a_valid || b_valid;
        s0_ev    = a_valid ? a_ev : b_ev;
        s0_act   = a_valid ? a_act : b_act;
        // drop the second event once the first terminates
        s1_valid = a_valid && b_valid && (a_act != ACT_TERMINATE);
        s0_res   = '{event_code: s0_ev, action: s0_act, last: !s1_valid};
        s1_res   = '{event_code: b_ev, action: b_act, last: 1'b1};
        n_terminated = r_terminated
                    || (s0_valid && (s0_act == ACT_TERMINATE))
                    || (s1_valid && (b_act == ACT_TERMINATE));
        push_n   = {1'b0, s0_valid} + {1'b0, s1_valid};
    end

    assign wr_ptr_1 = r_wr_ptr + PtrW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_timeout <= CPU_TIMEOUT_RST;
            r_cpu_failure <= CPU_FAILURE_RST;
            r_gps_timeout <= GPS_TIMEOUT_RST;
            r_gps_failure <= GPS_FAILURE_RST;
            r_bound_limit <= BOUND_LIMIT_RST;
            r_resp_table  <= RESP_TABLE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CPU_TIMEOUT: r_cpu_timeout <= i_cfg_data;
                CFG_CPU_FAILURE: r_cpu_failure <= i_cfg_data;
                CFG_GPS_TIMEOUT: r_gps_timeout <= i_cfg_data;
                CFG_GPS_FAILURE: r_gps_failure <= i_cfg_data;
                CFG_BOUND_LIMIT: r_bound_limit <= i_cfg_data[LimitW-1:0];
                CFG_RESP_TABLE:  r_resp_table  <= i_cfg_data[RespW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_delta  <= '0;
            r_gps_delta  <= '0;
            r_exceed     <= '0;
            r_terminated <= 1'b0;
        end else if (in_fire && !r_terminated) begin
            r_cpu_delta  <= n_cpu_delta;
            r_gps_delta  <= n_gps_delta;
            r_exceed     <= n_exceed;
            r_terminated <= n_terminated;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && !r_terminated) begin
            if (a_valid || b_valid) begin
                r_queue[r_wr_ptr] <= s0_res;
            end
            if (s1_valid) begin
                r_queue[wr_ptr_1] <= s1_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_fire && !r_terminated) begin
                r_wr_ptr <= r_wr_ptr + PtrW'(push_n);
            end
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + PtrW'(1);
            end
            r_count <= r_count
                     + ((in_fire && !r_terminated) ? CntW'(push_n) : CntW'(0))
                     - (out_fire ? CntW'(1) : CntW'(0));
        end
    end

    assign o_out_valid  = (r_count != '0);
    assign o_event_code = r_queue[r_rd_ptr].event_code;
    assign o_action     = r_queue[r_rd_ptr].action;
    assign o_last       = r_queue[r_rd_ptr].last;

endmodule
`default_nettype wire

>>> rtl/fsts_checker.sv
`default_nettype none
`include "assert_macros.svh"
module fsts_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_in_valid,
    input wire                               o_in_ready,
    input wire [fsts_pkg::FuncW-1:0]         i_func,
    input wire                               o_out_valid,
    input wire                               i_out_ready,
    input wire [fsts_pkg::EventW-1:0]        o_event_code,
    input wire [fsts_pkg::ActionW-1:0]       o_action,
    input wire                               o_last
);
    import fsts_pkg::*;

    `AST_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_event_code))
    `AST_SAME(a_term_is_last, o_out_valid && (o_action == ACT_TERMINATE), o_last)
    `AST_NEXT(a_silent_after_term, o_out_valid && i_out_ready && (o_action == ACT_TERMINATE), !o_out_valid)
    `AST_NEXT(a_cpu_seen_quiet, i_in_valid && o_in_ready && (i_func == FUNC_CPU_SEEN) && !o_out_valid, !o_out_valid)

endmodule

bind failsafe_timeout_supervisor fsts_checker u_fsts_checker (.*);
`default_nettype wire
